/* sv/assert_macros.svh */
// Assertion macros shared by the checker files.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define NSF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nsf assertion failed");

// Next-cycle implication, disabled while reset is asserted (active low).
`define NSF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nsf assertion failed");

`endif

/* sv/nsf_pkg.sv */
// Types and constants for the NMEA sentence framer.
// No dependencies; used by every module of the block by scoped names.
package nsf_pkg;

    // Characters the front end looks for
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;

    // Result status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_NO_DOLLAR  = 3'd1;
    localparam logic [2:0] ST_CSUM_LEN   = 3'd2;
    localparam logic [2:0] ST_CSUM_NOHEX = 3'd3;
    localparam logic [2:0] ST_BAD_ID     = 3'd4;

    // Sentence kinds
    localparam logic [3:0] KIND_UNKNOWN = 4'd0;
    localparam logic [3:0] KIND_GGA     = 4'd1;
    localparam logic [3:0] KIND_GNS     = 4'd2;
    localparam logic [3:0] KIND_GST     = 4'd3;
    localparam logic [3:0] KIND_RMC     = 4'd4;
    localparam logic [3:0] KIND_VTG     = 4'd5;
    localparam logic [3:0] KIND_THS     = 4'd6;
    localparam logic [3:0] KIND_GSA     = 4'd7;
    localparam logic [3:0] KIND_ZDA     = 4'd8;

    localparam int NUM_SUFFIX = 5;
    localparam int NUM_FORMAT = 8;

    // Secondary-antenna suffixes (four upper-case chars) and their kinds
    localparam logic [31:0] SUFFIX_TAB [NUM_SUFFIX] = '{
        32'h4747_4148, 32'h474E_5348, 32'h4753_5448, 32'h524D_4348, 32'h5654_4748
    };
    localparam logic [3:0] SUFFIX_KIND [NUM_SUFFIX] = '{
        KIND_GGA, KIND_GNS, KIND_GST, KIND_RMC, KIND_VTG
    };

    // Three-letter formatters and their kinds
    localparam logic [23:0] FORMAT_TAB [NUM_FORMAT] = '{
        24'h474741, 24'h474E53, 24'h475354, 24'h524D43,
        24'h565447, 24'h544853, 24'h475341, 24'h5A4441
    };
    localparam logic [3:0] FORMAT_KIND [NUM_FORMAT] = '{
        KIND_GGA, KIND_GNS, KIND_GST, KIND_RMC,
        KIND_VTG, KIND_THS, KIND_GSA, KIND_ZDA
    };

    // Parse phase of the current line
    typedef enum logic [1:0] {
        PH_WAIT   = 2'd0,
        PH_BODY   = 2'd1,
        PH_STAR   = 2'd2,
        PH_REJECT = 2'd3
    } phase_t;

    // Classified word handed from front end to back end
    typedef struct packed {
        logic [7:0] raw;
        logic [7:0] upper;
        logic [3:0] nibble;
        logic       is_hex;
        logic       is_space;
        logic       is_dollar;
        logic       is_star;
        logic       is_comma;
        logic       line_end;
    } class_t;

    // Running parse state of one line
    typedef struct packed {
        phase_t      phase;
        logic [7:0]  running_xor;
        logic [31:0] id_tail;
        logic [15:0] id_head;
        logic [7:0]  id_count;
        logic        id_closed;
        logic [7:0]  comma_count;
        logic [7:0]  star_count;
        logic [7:0]  hex_digits;
        logic [1:0]  hex_ok;
    } line_state_t;

    // One result word
    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  kind;
        logic        secondary;
        logic        present;
        logic        valid;
        logic [7:0]  computed;
        logic [7:0]  received;
        logic [7:0]  id_length;
        logic [7:0]  talker_length;
        logic [15:0] talker_chars;
        logic [7:0]  field_count;
    } result_t;

endpackage

/* sv/nsf_front.sv */
// Front end: classifies each incoming byte and registers the class word.
// Depends on nsf_pkg.
module nsf_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic [7:0]      s_line_byte,
    input  logic            s_line_end,
    output logic            out_valid,
    input  logic            out_ready,
    output nsf_pkg::class_t out_item
);

    nsf_pkg::class_t cls;
    nsf_pkg::class_t item_reg;
    logic            valid_reg;

    // Byte classification
    always_comb begin
        cls           = '0;
        cls.raw       = s_line_byte;
        cls.line_end  = s_line_end;
        cls.is_space  = s_line_byte inside {nsf_pkg::CH_SPACE, nsf_pkg::CH_TAB,
                                            nsf_pkg::CH_CR, nsf_pkg::CH_LF};
        cls.is_dollar = (s_line_byte == nsf_pkg::CH_DOLLAR);
        cls.is_star   = (s_line_byte == nsf_pkg::CH_STAR);
        cls.is_comma  = (s_line_byte == nsf_pkg::CH_COMMA);
        cls.upper     = s_line_byte;
        if (s_line_byte inside {[8'h61:8'h7A]}) begin
            cls.upper = s_line_byte & 8'hDF;
        end
        if (s_line_byte inside {[8'h30:8'h39]}) begin
            cls.is_hex = 1'b1;
            cls.nibble = s_line_byte[3:0];
        end else if (s_line_byte inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
            cls.is_hex = 1'b1;
            cls.nibble = s_line_byte[3:0] + 4'd9;
        end
    end

    assign s_ready   = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    // Stage register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            valid_reg <= 1'b1;
        end else if (out_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= cls;
        end
    end

endmodule

/* sv/nsf_fifo.sv */
// Short flip-flop queue between front and back end.
// Depends on nsf_pkg (class word type).
module nsf_fifo #(
    parameter int DEPTH = 2
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push_valid,
    output logic            push_ready,
    input  nsf_pkg::class_t push_item,
    output logic            pop_valid,
    input  logic            pop_ready,
    output nsf_pkg::class_t pop_item
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    nsf_pkg::class_t mem_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic            do_push;
    logic            do_pop;

    assign push_ready = (count_reg != FULL);
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* sv/nsf_back.sv */
// Back end: per-byte line parser, trailing-blank snapshot, result register.
// Depends on nsf_pkg.
module nsf_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  nsf_pkg::class_t in_item,
    output logic            m_valid,
    input  logic            m_ready,
    output nsf_pkg::result_t m_result
);

    nsf_pkg::line_state_t live_reg;
    nsf_pkg::line_state_t kept_reg;
    nsf_pkg::line_state_t live_next;
    nsf_pkg::line_state_t kept_next;
    nsf_pkg::result_t     result_next;
    nsf_pkg::result_t     result_reg;
    logic                 out_valid_reg;
    logic                 out_free;
    logic                 take;

    function automatic logic [7:0] sat_inc(input logic [7:0] v);
        return (v == 8'hFF) ? v : v + 8'd1;
    endfunction

    // One byte through the line parser
    function automatic nsf_pkg::line_state_t step(input nsf_pkg::line_state_t s,
                                                  input nsf_pkg::class_t c);
        nsf_pkg::line_state_t r;
        r = s;
        case (s.phase)
            nsf_pkg::PH_WAIT: begin
                if (!c.is_space) begin
                    r.phase = c.is_dollar ? nsf_pkg::PH_BODY : nsf_pkg::PH_REJECT;
                end
            end
            nsf_pkg::PH_BODY: begin
                if (c.is_star) begin
                    r.phase = nsf_pkg::PH_STAR;
                end else begin
                    r.running_xor = s.running_xor ^ c.raw;
                    if (c.is_comma) begin
                        r.comma_count = sat_inc(s.comma_count);
                        r.id_closed   = 1'b1;
                    end else if (!s.id_closed) begin
                        if (s.id_count == 8'd0) begin
                            r.id_head = {c.upper, 8'h00};
                        end else if (s.id_count == 8'd1) begin
                            r.id_head = {s.id_head[15:8], c.upper};
                        end
                        r.id_tail  = {s.id_tail[23:0], c.upper};
                        r.id_count = sat_inc(s.id_count);
                    end
                end
            end
            nsf_pkg::PH_STAR: begin
                if (s.star_count < 8'd2 && c.is_hex) begin
                    if (s.star_count == 8'd0) begin
                        r.hex_digits = {c.nibble, 4'h0};
                        r.hex_ok     = s.hex_ok | 2'b10;
                    end else begin
                        r.hex_digits = s.hex_digits | {4'h0, c.nibble};
                        r.hex_ok     = s.hex_ok | 2'b01;
                    end
                end
                r.star_count = sat_inc(s.star_count);
            end
            default: begin
                r = s;
            end
        endcase
        return r;
    endfunction

    // Result from the snapshot taken at the last non-blank byte
    function automatic nsf_pkg::result_t finish(input nsf_pkg::line_state_t s);
        nsf_pkg::result_t r;
        logic             found;
        logic [7:0]       flen;
        r     = '0;
        found = 1'b0;
        flen  = 8'd3;
        if (s.phase == nsf_pkg::PH_WAIT || s.phase == nsf_pkg::PH_REJECT) begin
            r.status = nsf_pkg::ST_NO_DOLLAR;
        end else begin
            r.status      = nsf_pkg::ST_OK;
            r.computed    = s.running_xor;
            r.id_length   = s.id_count;
            r.field_count = sat_inc(s.comma_count);
            if (s.phase == nsf_pkg::PH_STAR) begin
                r.present = 1'b1;
                if (s.star_count != 8'd2) begin
                    r.status = nsf_pkg::ST_CSUM_LEN;
                end else if (s.hex_ok != 2'b11) begin
                    r.status = nsf_pkg::ST_CSUM_NOHEX;
                end else begin
                    r.received = s.hex_digits;
                    r.valid    = (s.hex_digits == s.running_xor);
                end
            end
            if (r.status == nsf_pkg::ST_OK && s.id_count < 8'd3) begin
                r.status = nsf_pkg::ST_BAD_ID;
            end
            if (r.status == nsf_pkg::ST_OK) begin
                if (s.id_count >= 8'd4) begin
                    for (int i = 0; i < nsf_pkg::NUM_SUFFIX; i++) begin
                        if (!found && s.id_tail == nsf_pkg::SUFFIX_TAB[i]) begin
                            found       = 1'b1;
                            r.secondary = 1'b1;
                            r.kind      = nsf_pkg::SUFFIX_KIND[i];
                            flen        = 8'd4;
                        end
                    end
                end
                for (int i = 0; i < nsf_pkg::NUM_FORMAT; i++) begin
                    if (!found && s.id_tail[23:0] == nsf_pkg::FORMAT_TAB[i]) begin
                        found  = 1'b1;
                        r.kind = nsf_pkg::FORMAT_KIND[i];
                    end
                end
                r.talker_length = s.id_count - flen;
                r.talker_chars  = s.id_head;
            end
        end
        return r;
    endfunction

    // Next parse state and snapshot
    always_comb begin
        live_next   = step(live_reg, in_item);
        kept_next   = in_item.is_space ? kept_reg : live_next;
        result_next = finish(kept_next);
    end

    // Only a line-end word needs the output slot
    assign out_free = !out_valid_reg || m_ready;
    assign in_ready = !in_item.line_end || out_free;
    assign take     = in_valid && in_ready;
    assign m_valid  = out_valid_reg;
    assign m_result = result_reg;

    // Line state, cleared after each line end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            live_reg <= '0;
            kept_reg <= '0;
        end else if (take) begin
            if (in_item.line_end) begin
                live_reg <= '0;
                kept_reg <= '0;
            end else begin
                live_reg <= live_next;
                kept_reg <= kept_next;
            end
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (take && in_item.line_end) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take && in_item.line_end) begin
            result_reg <= result_next;
        end
    end

endmodule

/* sv/nmea_sentence_framer.sv */
// NMEA 0183 sentence framer: top level, front end + queue + back end.
// Depends on nsf_pkg, nsf_front, nsf_fifo, nsf_back.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+--------------------------------------
//  s_      | in  | s_valid / s_ready  | line_byte, line_end (one word a byte)
//  m_      | out | m_valid / m_ready  | eleven result fields, one per line
//
// One byte per cycle while s_ready is high; the back end's per-byte parser update
// sets the rate. A line-end word reaches m_ through the front register, the queue
// and the result register, in that order.
// Reset is synchronous, active low, and clears all line state.
// When m_ stalls, bytes keep flowing until the next line end reaches the back
// end; then the queue and the front register fill and s_ready drops.
module nmea_sentence_framer #(
    parameter int FIFO_DEPTH = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_line_byte,
    input  logic        s_line_end,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [3:0]  m_sentence_kind,
    output logic        m_second_antenna,
    output logic        m_csum_seen,
    output logic        m_csum_ok,
    output logic [7:0]  m_computed_checksum,
    output logic [7:0]  m_received_checksum,
    output logic [7:0]  m_identifier_length,
    output logic [7:0]  m_talker_length,
    output logic [15:0] m_talker_chars,
    output logic [7:0]  m_field_count
);

    nsf_pkg::class_t  front_item;
    nsf_pkg::class_t  queue_item;
    nsf_pkg::result_t result;
    logic             front_valid;
    logic             front_ready;
    logic             queue_valid;
    logic             queue_ready;

    nsf_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_line_byte (s_line_byte),
        .s_line_end  (s_line_end),
        .out_valid   (front_valid),
        .out_ready   (front_ready),
        .out_item    (front_item)
    );

    nsf_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_item  (front_item),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready),
        .pop_item   (queue_item)
    );

    nsf_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (queue_valid),
        .in_ready (queue_ready),
        .in_item  (queue_item),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (result)
    );

    // Result fields onto their ports
    assign m_status            = result.status;
    assign m_sentence_kind     = result.kind;
    assign m_second_antenna    = result.secondary;
    assign m_csum_seen         = result.present;
    assign m_csum_ok           = result.valid;
    assign m_computed_checksum = result.computed;
    assign m_received_checksum = result.received;
    assign m_identifier_length = result.id_length;
    assign m_talker_length     = result.talker_length;
    assign m_talker_chars      = result.talker_chars;
    assign m_field_count       = result.field_count;

endmodule

/* sv/nsf_checker.sv */
// Port-level checks on the sentence framer, bound to the top level.
// Depends on assert_macros.svh and nsf_pkg.
`include "assert_macros.svh"

module nsf_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_status,
    input logic [3:0]  m_sentence_kind,
    input logic        m_second_antenna,
    input logic        m_csum_seen,
    input logic        m_csum_ok,
    input logic [7:0]  m_computed_checksum,
    input logic [7:0]  m_received_checksum,
    input logic [7:0]  m_field_count
);

    // A stalled result word holds
    `NSF_ASSERT_NXT(a_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_status) && $stable(m_computed_checksum))

    // A missing-dollar line reports nothing else
    `NSF_ASSERT_IMP(a_nodollar, aclk, aresetn, m_valid && m_status == nsf_pkg::ST_NO_DOLLAR,
        m_field_count == 8'd0 && m_computed_checksum == 8'd0 && !m_csum_seen)

    // A framed line always counts at least one field
    `NSF_ASSERT_IMP(a_fields, aclk, aresetn, m_valid && m_status != nsf_pkg::ST_NO_DOLLAR,
        m_field_count != 8'd0)

    // A good checksum needs a star and matching digits
    `NSF_ASSERT_IMP(a_csum, aclk, aresetn, m_valid && m_csum_ok,
        m_csum_seen && m_received_checksum == m_computed_checksum)

    // Secondary antenna only on a good line with a known kind
    `NSF_ASSERT_IMP(a_second, aclk, aresetn, m_valid && m_second_antenna,
        m_status == nsf_pkg::ST_OK && m_sentence_kind != nsf_pkg::KIND_UNKNOWN)

endmodule

bind nmea_sentence_framer nsf_checker u_nsf_checker (.*);

/* tb/sv/nsf_checker.sv */
// Checker for the NMEA sentence framer: watches both channels, predicts each frame word.
// Depends on nsf_pkg for the character, status and kind constants and the phase enum.
module nsf_scoreboard (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_line_byte,
    input  logic        s_line_end,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [2:0]  m_status,
    input  logic [3:0]  m_sentence_kind,
    input  logic        m_second_antenna,
    input  logic        m_csum_seen,
    input  logic        m_csum_ok,
    input  logic [7:0]  m_computed_checksum,
    input  logic [7:0]  m_received_checksum,
    input  logic [7:0]  m_identifier_length,
    input  logic [7:0]  m_talker_length,
    input  logic [15:0] m_talker_chars,
    input  logic [7:0]  m_field_count,
    output int unsigned mismatch_count,
    output int unsigned frames_pending,
    output int unsigned frames_checked
);
    timeunit 1ns;
    timeprecision 1ps;
    import nsf_pkg::*;

    // Parse progress through one line
    typedef struct packed {
        phase_t      phase;
        logic [7:0]  xor_sum;
        logic [31:0] id_last4;
        logic [15:0] id_first2;
        logic [7:0]  id_len;
        logic        id_done;
        logic [7:0]  commas;
        logic [7:0]  tail_len;
        logic [7:0]  rx_sum;
        logic [1:0]  nibbles_seen;
    } sentence_scan_t;

    // One frame word as it should leave the block
    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  kind;
        logic        secondary;
        logic        present;
        logic        valid;
        logic [7:0]  computed;
        logic [7:0]  received;
        logic [7:0]  id_length;
        logic [7:0]  talker_length;
        logic [15:0] talker_chars;
        logic [7:0]  field_count;
    } frame_fields_t;

    localparam logic [31:0] H_SUFFIXES [5] = '{"GGAH", "GNSH", "GSTH", "RMCH", "VTGH"};
    localparam logic [3:0]  H_KINDS    [5] = '{KIND_GGA, KIND_GNS, KIND_GST, KIND_RMC, KIND_VTG};
    localparam logic [23:0] FORMATTERS [8] = '{"GGA", "GNS", "GST", "RMC",
                                               "VTG", "THS", "GSA", "ZDA"};
    localparam logic [3:0]  FORMATTER_KINDS [8] = '{KIND_GGA, KIND_GNS, KIND_GST, KIND_RMC,
                                                    KIND_VTG, KIND_THS, KIND_GSA, KIND_ZDA};

    sentence_scan_t scan_live;
    sentence_scan_t scan_kept;
    frame_fields_t  expected_frames[$];
    frame_fields_t  seen_frame;
    frame_fields_t  want_frame;

    initial begin
        mismatch_count = 0;
        frames_pending = 0;
        frames_checked = 0;
    end

    function automatic logic [7:0] sat_add1(logic [7:0] v);
        return (v == 8'hFF) ? v : v + 8'd1;
    endfunction

    function automatic logic is_blank(logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
    endfunction

    // {is hex, value}
    function automatic logic [4:0] hex_digit(logic [7:0] c);
        if (c >= "0" && c <= "9") return {1'b1, c[3:0]};
        if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f")) return {1'b1, c[3:0] + 4'd9};
        return 5'd0;
    endfunction

    // Advance the parse by one byte
    function automatic sentence_scan_t scan_byte(sentence_scan_t s, logic [7:0] c);
        logic [7:0] up;
        logic [4:0] hd;
        up = (c >= "a" && c <= "z") ? c - 8'd32 : c;
        hd = hex_digit(c);
        case (s.phase)
            PH_WAIT: begin
                if (!is_blank(c)) begin
                    if (c == CH_DOLLAR) s.phase = PH_BODY;
                    else s.phase = PH_REJECT;
                end
            end
            PH_BODY: begin
                if (c == CH_STAR) begin
                    s.phase = PH_STAR;
                end else begin
                    s.xor_sum ^= c;
                    if (c == CH_COMMA) begin
                        s.commas  = sat_add1(s.commas);
                        s.id_done = 1'b1;
                    end else if (!s.id_done) begin
                        if (s.id_len == 8'd0) s.id_first2 = {up, 8'h00};
                        else if (s.id_len == 8'd1) s.id_first2[7:0] = up;
                        s.id_last4 = {s.id_last4[23:0], up};
                        s.id_len   = sat_add1(s.id_len);
                    end
                end
            end
            PH_STAR: begin
                // anything after the star counts toward the checksum length
                if (s.tail_len < 8'd2 && hd[4]) begin
                    if (s.tail_len == 8'd0) begin
                        s.rx_sum          = {hd[3:0], 4'h0};
                        s.nibbles_seen[1] = 1'b1;
                    end else begin
                        s.rx_sum[3:0]     = hd[3:0];
                        s.nibbles_seen[0] = 1'b1;
                    end
                end
                s.tail_len = sat_add1(s.tail_len);
            end
            default: ;
        endcase
        return s;
    endfunction

    // Frame word for a finished (trimmed) line
    function automatic frame_fields_t frame_of(sentence_scan_t s);
        frame_fields_t r;
        logic [7:0]    fmt_len;
        r = '0;
        if (s.phase == PH_WAIT || s.phase == PH_REJECT) begin
            r.status = ST_NO_DOLLAR;
            return r;
        end
        r.status      = ST_OK;
        r.computed    = s.xor_sum;
        r.id_length   = s.id_len;
        r.field_count = sat_add1(s.commas);
        if (s.phase == PH_STAR) begin
            r.present = 1'b1;
            if (s.tail_len != 8'd2) begin
                r.status = ST_CSUM_LEN;
            end else if (s.nibbles_seen != 2'b11) begin
                r.status = ST_CSUM_NOHEX;
            end else begin
                r.received = s.rx_sum;
                r.valid    = (s.rx_sum == s.xor_sum);
            end
        end
        if (r.status == ST_OK && s.id_len < 8'd3) r.status = ST_BAD_ID;
        if (r.status == ST_OK) begin
            fmt_len = 8'd3;
            r.kind  = KIND_UNKNOWN;
            if (s.id_len >= 8'd4) begin
                for (int i = 0; i < 5; i++) begin
                    if (!r.secondary && s.id_last4 == H_SUFFIXES[i]) begin
                        r.secondary = 1'b1;
                        r.kind      = H_KINDS[i];
                        fmt_len     = 8'd4;
                    end
                end
            end
            if (!r.secondary) begin
                for (int i = 0; i < 8; i++) begin
                    if (r.kind == KIND_UNKNOWN && s.id_last4[23:0] == FORMATTERS[i])
                        r.kind = FORMATTER_KINDS[i];
                end
            end
            r.talker_length = s.id_len - fmt_len;
            r.talker_chars  = s.id_first2;
        end
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        mismatch_count++;
        $display("[%0t] MISMATCH %s", $realtime, msg);
    endtask

    task automatic check_field(string name, int unsigned got, int unsigned want);
        if (got != want)
            report_mismatch($sformatf("frame %0d %s: got 0x%0h, expected 0x%0h",
                                      frames_checked, name, got, want));
    endtask

    // Predict on accepted bytes, compare on accepted frame words
    always @(posedge aclk) begin
        if (!aresetn) begin
            scan_live = '0;
            scan_kept = '0;
            expected_frames.delete();
        end else begin
            if (s_valid && s_ready) begin
                scan_live = scan_byte(scan_live, s_line_byte);
                // trailing whitespace is trimmed by reporting the last solid state
                if (!is_blank(s_line_byte)) scan_kept = scan_live;
                if (s_line_end) begin
                    expected_frames.insert(expected_frames.size(), frame_of(scan_kept));
                    scan_live = '0;
                    scan_kept = '0;
                end
            end
            if (m_valid && m_ready) begin
                seen_frame = '{m_status, m_sentence_kind, m_second_antenna,
                               m_csum_seen, m_csum_ok, m_computed_checksum,
                               m_received_checksum, m_identifier_length, m_talker_length,
                               m_talker_chars, m_field_count};
                if (expected_frames.size() == 0) begin
                    report_mismatch($sformatf("frame word with no line pending: 0x%0h",
                                              seen_frame));
                end else begin
                    want_frame = expected_frames.pop_front();
                    check_field("status", seen_frame.status, want_frame.status);
                    check_field("sentence_kind", seen_frame.kind, want_frame.kind);
                    check_field("second_antenna", seen_frame.secondary,
                                want_frame.secondary);
                    check_field("csum_seen", seen_frame.present, want_frame.present);
                    check_field("csum_ok", seen_frame.valid, want_frame.valid);
                    check_field("computed_checksum", seen_frame.computed,
                                want_frame.computed);
                    check_field("received_checksum", seen_frame.received,
                                want_frame.received);
                    check_field("identifier_length", seen_frame.id_length,
                                want_frame.id_length);
                    check_field("talker_length", seen_frame.talker_length,
                                want_frame.talker_length);
                    check_field("talker_chars", seen_frame.talker_chars,
                                want_frame.talker_chars);
                    check_field("field_count", seen_frame.field_count,
                                want_frame.field_count);
                end
                frames_checked++;
            end
        end
        frames_pending = expected_frames.size();
    end

endmodule

/* tb/sv/nmea_sentence_framer_tb.sv */
// Top of the NMEA sentence framer testbench: clock, reset, line stimulus, verdict.
// Depends on nsf_pkg, nmea_sentence_framer and nsf_scoreboard.
module nmea_sentence_framer_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import nsf_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_line_byte = 8'h00;
    logic        s_line_end = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_status;
    logic [3:0]  m_sentence_kind;
    logic        m_second_antenna;
    logic        m_csum_seen;
    logic        m_csum_ok;
    logic [7:0]  m_computed_checksum;
    logic [7:0]  m_received_checksum;
    logic [7:0]  m_identifier_length;
    logic [7:0]  m_talker_length;
    logic [15:0] m_talker_chars;
    logic [7:0]  m_field_count;

    int unsigned mismatch_count;
    int unsigned frames_pending;
    int unsigned frames_checked;

    int unsigned send_idle_pct = 9;
    int unsigned recv_idle_pct = 65;
    int unsigned hold_requests = 0;
    int unsigned bytes_sent = 0;
    int unsigned lines_sent = 0;
    int unsigned random_bytes = 0;
    int unsigned random_lines = 0;
    bit [7:0]    line_buf[$];

    string formatter_names[13] = '{"GGA", "GNS", "GST", "RMC", "VTG", "THS", "GSA", "ZDA",
                                   "GGAH", "GNSH", "GSTH", "RMCH", "VTGH"};
    string talker_names[5] = '{"GP", "GN", "GL", "IN", "gp"};
    string field_set = "0123456789.-NSEWAM";
    string blank_set = " \t\015\n";

    always #6 aclk = ~aclk;

    nmea_sentence_framer u_top (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_line_byte         (s_line_byte),
        .s_line_end          (s_line_end),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_status            (m_status),
        .m_sentence_kind     (m_sentence_kind),
        .m_second_antenna    (m_second_antenna),
        .m_csum_seen         (m_csum_seen),
        .m_csum_ok           (m_csum_ok),
        .m_computed_checksum (m_computed_checksum),
        .m_received_checksum (m_received_checksum),
        .m_identifier_length (m_identifier_length),
        .m_talker_length     (m_talker_length),
        .m_talker_chars      (m_talker_chars),
        .m_field_count       (m_field_count)
    );

    nsf_scoreboard u_check (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_line_byte         (s_line_byte),
        .s_line_end          (s_line_end),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_status            (m_status),
        .m_sentence_kind     (m_sentence_kind),
        .m_second_antenna    (m_second_antenna),
        .m_csum_seen         (m_csum_seen),
        .m_csum_ok           (m_csum_ok),
        .m_computed_checksum (m_computed_checksum),
        .m_received_checksum (m_received_checksum),
        .m_identifier_length (m_identifier_length),
        .m_talker_length     (m_talker_length),
        .m_talker_chars      (m_talker_chars),
        .m_field_count       (m_field_count),
        .mismatch_count      (mismatch_count),
        .frames_pending      (frames_pending),
        .frames_checked      (frames_checked)
    );

    // Receiver: random idling, plus a long hold-off whenever one is requested
    initial begin
        int unsigned holds_served;
        int unsigned hold_left;
        holds_served = 0;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (holds_served != hold_requests) begin
                holds_served = hold_requests;
                hold_left = 400;
            end
            if (hold_left != 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Run limit
    initial begin
        #5_000_000;
        $display("Timeout with %0d frames still pending", frames_pending);
        $display("DONE: errors detected");
        $finish;
    end

    function automatic bit [7:0] hex_char(bit [3:0] n, bit lower);
        bit [7:0] c;
        c = (n < 4'd10) ? 8'h30 + n : 8'h37 + n;
        if (lower && n >= 4'd10) c |= 8'h20;
        return c;
    endfunction

    // XOR of the bytes between the first dollar and the first star after it
    function automatic bit [7:0] payload_xor();
        bit [7:0] x;
        bit       in_body;
        x = 8'h00;
        in_body = 1'b0;
        foreach (line_buf[i]) begin
            if (in_body && line_buf[i] == CH_STAR) break;
            if (in_body) x ^= line_buf[i];
            else if (line_buf[i] == CH_DOLLAR) in_body = 1'b1;
        end
        return x;
    endfunction

    function automatic bit [7:0] rand_letter();
        bit [7:0] c;
        c = 8'h41 + 8'($urandom_range(25));
        if ($urandom_range(4) == 0) c |= 8'h20;
        return c;
    endfunction

    // Append one byte to the line under construction
    task automatic put_byte(bit [7:0] b);
        line_buf.insert(line_buf.size(), b);
    endtask

    task automatic put_text(string t);
        for (int i = 0; i < t.len(); i++) put_byte(t[i]);
    endtask

    task automatic put_checksum(bit [7:0] value, bit lower);
        put_byte(CH_STAR);
        put_byte(hex_char(value[7:4], lower));
        put_byte(hex_char(value[3:0], lower));
    endtask

    // One word on the input channel; valid holds until accepted
    task automatic send_word(bit [7:0] b, bit last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_line_byte <= b;
        s_line_end  <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        bytes_sent++;
    endtask

    task automatic send_line();
        foreach (line_buf[i]) send_word(line_buf[i], i == line_buf.size() - 1);
        lines_sent++;
        line_buf.delete();
    endtask

    // Mostly well-formed sentences with random content, some noise and broken ones
    task automatic build_random_line();
        int unsigned pick;
        bit [7:0]    sum;
        if ($urandom_range(99) < 8) begin
            repeat ($urandom_range(1, 12)) put_byte(8'($urandom_range(255)));
            return;
        end
        if ($urandom_range(3) == 0)
            repeat ($urandom_range(1, 3)) put_byte(blank_set[$urandom_range(3)]);
        if ($urandom_range(19) == 0) put_byte(rand_letter());
        else put_byte(CH_DOLLAR);
        // identifier
        pick = $urandom_range(9);
        if (pick == 0) begin
            repeat ($urandom_range(0, 2)) put_byte(rand_letter());
        end else if (pick == 1) begin
            repeat ($urandom_range(3, 7)) put_byte(rand_letter());
        end else begin
            if ($urandom_range(4) == 0) begin
                put_byte(rand_letter());
                put_byte(rand_letter());
            end else begin
                put_text(talker_names[$urandom_range(4)]);
            end
            put_text(formatter_names[$urandom_range(12)]);
            if ($urandom_range(9) == 0) line_buf[line_buf.size() - 1] |= 8'h20;
        end
        // fields
        repeat ($urandom_range(0, 6)) begin
            put_byte(CH_COMMA);
            repeat ($urandom_range(0, 5)) begin
                if ($urandom_range(19) == 0) put_byte(8'($urandom_range(255)));
                else put_byte(field_set[$urandom_range(field_set.len() - 1)]);
            end
        end
        // checksum tail, mostly correct
        sum = payload_xor();
        pick = $urandom_range(19);
        if (pick >= 2 && pick <= 13) begin
            put_checksum(sum, $urandom_range(1));
        end else if (pick == 14) begin
            put_checksum(sum ^ 8'($urandom_range(1, 255)), $urandom_range(1));
        end else if (pick == 15) begin
            put_byte(CH_STAR);
            put_byte(hex_char(sum[7:4], 1'b0));
        end else if (pick == 16) begin
            put_checksum(sum, 1'b0);
            put_byte(hex_char(4'($urandom_range(15)), 1'b0));
        end else if (pick == 17) begin
            put_checksum(sum, 1'b0);
            line_buf[line_buf.size() - 1 - $urandom_range(1)] = rand_letter() | 8'h10;
        end else if (pick == 18) begin
            put_byte(CH_STAR);
            put_byte(CH_STAR);
            put_byte(hex_char(sum[3:0], 1'b0));
        end else if (pick == 19) begin
            put_byte(CH_STAR);
        end
        // trailing whitespace, now and then with a stray byte behind it
        pick = $urandom_range(9);
        if (pick < 5) begin
            put_text("\015\n");
        end else if (pick < 7) begin
            repeat ($urandom_range(1, 3)) put_byte(blank_set[$urandom_range(3)]);
        end else if (pick == 7) begin
            put_byte(CH_SPACE);
            put_byte(rand_letter());
        end
    endtask

    // Random lines until this phase has sent its share of bytes and lines
    task automatic run_random(int unsigned byte_goal, int unsigned line_goal);
        int unsigned bytes_at_start;
        int unsigned lines_at_start;
        bytes_at_start = random_bytes;
        lines_at_start = random_lines;
        while (random_bytes - bytes_at_start < byte_goal ||
               random_lines - lines_at_start < line_goal) begin
            build_random_line();
            random_bytes += line_buf.size();
            random_lines++;
            send_line();
        end
    endtask

    // Stimulus and verdict
    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed lines: blank and short lines, every formatter and suffix
        put_text("\n");
        send_line();
        put_text(" \t\015\n");
        send_line();
        put_text("$");
        send_line();
        put_text("GPGGA,1*00\015\n");
        send_line();
        foreach (formatter_names[i]) begin
            if (i == 7) put_text(" \t$gn");
            else put_text("$GP");
            put_text(formatter_names[i]);
            put_checksum(payload_xor(), i[0]);
            send_line();
        end
        put_text("$GPXYZ,1");
        send_line();
        // checksum faults: short, long, not hex, double star, stray byte after blanks, wrong value
        put_text("$GPGGA,1*4");
        send_line();
        put_text("$GPGGA,1*4AB");
        send_line();
        put_text("$GPGGA,1*G1");
        send_line();
        put_text("$GPGGA**1\n");
        send_line();
        put_text("$GPVTG*AB X\n");
        send_line();
        put_text("$GPRMC,1*00 \015\n");
        send_line();
        // identifier too short, with a good checksum
        put_text("$GP,1");
        put_checksum(payload_xor(), 1'b0);
        send_line();
        // byte extremes inside a field
        put_text("$GPGGA,");
        put_byte(8'hFF);
        put_byte(8'h00);
        put_checksum(payload_xor(), 1'b0);
        send_line();

        run_random(70, 3);
        send_idle_pct = 65;
        recv_idle_pct = 9;
        run_random(70, 3);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_requests++;
        run_random(70, 3);
        s_valid <= 1'b0;
        @(posedge aclk);

        while (frames_pending != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        $display("Sent %0d lines (%0d bytes, %0d random lines); %0d frame words checked.",
                 lines_sent, bytes_sent, random_lines, frames_checked);
        $display("Covered blank, malformed and bad-checksum lines under three idle mixes.");
        if (mismatch_count == 0 && frames_pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
